/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// Types and constants shared by the KMP substring matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

   // Pattern capacity and derived widths
   localparam int PATTERN_MAX = 64;
   localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int CODE_W      = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 8;

   // Input kind codes
   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TITLE   = 1'b1;

   // Classified operation
   typedef enum logic [1:0] {
      OP_PATTERN_NEW,
      OP_PATTERN_ADD,
      OP_TITLE_NEW,
      OP_TITLE_CONT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CODE_W-1:0]   code;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic ovf;
      logic done;
      logic found;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] prog;
      logic [LEN_W-1:0] bp;
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_FIX,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

/* rtl/kmp_substring_matcher.sv */
// ----------------------------------------------------------------------------
// kmp_substring_matcher
// Streaming KMP substring search over 16-bit code units, one result per item.
// ----------------------------------------------------------------------------
// Each result passes through queue entry, back-end sequencing and the output
//   register; a unit that needs comparison adds a compare step per fallback,
//   and a full match adds a fix step that fetches its failure value.
// The back end takes a new item only once the last result is in the output register;
//   each fallback step waits on registered RAM read data.
// Reset: synchronous; clears queue, lengths, progress and flags, not the RAMs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kmp_substring_matcher (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [kmp_pkg::REQ_DATA_W-1:0]   req_tdata,  // [15:0] code_unit
   input  wire logic [kmp_pkg::REQ_USER_W-1:0]   req_tuser,  // [0] kind, [1] first
   input  wire logic                             req_tlast,  // last
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [kmp_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [0] found, [1] pattern_overflow
   output logic                                  rsp_tlast   // title_done
);
   import kmp_pkg::*;

   logic       cmd_valid;
   logic       cmd_ready;
   cmd_type    cmd;
   rsp_type    rsp;
   status_type status;

   kmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   kmp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .status    (status)
   );

   // Pack result fields
   assign rsp_tdata = {(RSP_DATA_W - 2)'(0), rsp.ovf, rsp.found};
   assign rsp_tlast = rsp.done;

   `ASSERT_ALWAYS(a_len_in_range, status.len <= LEN_W'(PATTERN_MAX),
      "pattern length beyond capacity")
   `ASSERT_ALWAYS(a_prog_in_range, (status.prog == '0) || (status.prog < status.len),
      "match progress not below pattern length")
   `ASSERT_ALWAYS(a_bp_in_range, (status.bp == '0) || (status.bp < status.len),
      "build prefix not below pattern length")
   `ASSERT_NEXT(a_pop_busy, cmd_valid && cmd_ready, status.busy,
      "command taken but back end stayed idle")

endmodule

`default_nettype wire

/* rtl/kmp_ram.sv */
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, and register the read data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

/* rtl/kmp_front.sv */
// ----------------------------------------------------------------------------
// kmp_front
// Accepts input transactions, classifies them and queues the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [kmp_pkg::REQ_DATA_W-1:0]   req_tdata,  // [15:0] code_unit
   input  wire logic [kmp_pkg::REQ_USER_W-1:0]   req_tuser,  // [0] kind, [1] first
   input  wire logic                             req_tlast,  // last
   output logic                                  cmd_valid,
   input  wire logic                             cmd_ready,
   output kmp_pkg::cmd_type                      cmd
);
   import kmp_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             new_cmd;
   logic                push;
   logic                pop;

   // Classify the incoming transaction
   always_comb begin
      new_cmd.code = req_tdata[CODE_W-1:0];
      new_cmd.last = req_tlast;
      if (req_tuser[0] == KIND_TITLE) begin
         new_cmd.op = req_tuser[1] ? OP_TITLE_NEW : OP_TITLE_CONT;
      end else begin
         new_cmd.op = req_tuser[1] ? OP_PATTERN_NEW : OP_PATTERN_ADD;
      end
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified command
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/kmp_back.sv */
// ----------------------------------------------------------------------------
// kmp_back
// Executes queued commands: builds the failure table, runs the KMP search
// with fallback steps, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           cmd_valid,
   output logic                cmd_ready,
   input  wire kmp_pkg::cmd_type cmd,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output kmp_pkg::rsp_type    rsp,
   output kmp_pkg::status_type status
);
   import kmp_pkg::*;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   bp_ff, bp_in;
   logic [LEN_W-1:0]   prog_ff, prog_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   logic               found_ff, found_in;
   logic               ovf_ff, ovf_in;
   cmd_type            cur_ff, cur_in;
   rsp_type            res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic               st_we;
   logic [IDX_W-1:0]   st_waddr;
   logic [CODE_W-1:0]  st_wdata;
   logic [IDX_W-1:0]   st_raddr;
   logic [CODE_W-1:0]  st_rdata;
   logic               fl_we;
   logic [IDX_W-1:0]   fl_waddr;
   logic [LEN_W-1:0]   fl_wdata;
   logic [IDX_W-1:0]   fl_raddr;
   logic [LEN_W-1:0]   fl_rdata;
   logic [LEN_W-1:0]   k_dec;

   kmp_ram #(.WIDTH(CODE_W), .DEPTH(PATTERN_MAX)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   kmp_ram #(.WIDTH(LEN_W), .DEPTH(PATTERN_MAX)) u_fail (
      .clock (clock),
      .we    (fl_we),
      .waddr (fl_waddr),
      .wdata (fl_wdata),
      .raddr (fl_raddr),
      .rdata (fl_rdata)
   );

   // Sequence one command at a time
   always_comb begin
      logic             is_new;
      logic [LEN_W-1:0] len_eff;
      logic [LEN_W-1:0] bp_eff;
      logic             ovf_eff;
      logic             found_eff;
      logic [LEN_W-1:0] prog_eff;
      logic             hit;
      logic [LEN_W-1:0] k_next;

      state_in     = state_ff;
      len_in       = len_ff;
      bp_in        = bp_ff;
      prog_in      = prog_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      cmd_ready    = 1'b0;
      st_we        = 1'b0;
      st_waddr     = len_ff[IDX_W-1:0];
      st_wdata     = cur_ff.code;
      fl_we        = 1'b0;
      fl_waddr     = len_ff[IDX_W-1:0];
      fl_wdata     = '0;
      is_new       = 1'b0;
      len_eff      = len_ff;
      bp_eff       = bp_ff;
      ovf_eff      = ovf_ff;
      found_eff    = found_ff;
      prog_eff     = prog_ff;
      hit          = (st_rdata == cur_ff.code);
      k_next       = k_ff + LEN_W'(hit);

      // Drop the output transaction once taken
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cur_in = cmd;
               case (cmd.op)
                  OP_PATTERN_NEW, OP_PATTERN_ADD: begin
                     is_new  = (cmd.op == OP_PATTERN_NEW);
                     len_eff = is_new ? '0 : len_ff;
                     bp_eff  = is_new ? '0 : bp_ff;
                     ovf_eff = is_new ? 1'b0 : ovf_ff;
                     prog_in = '0;
                     len_in  = len_eff;
                     bp_in   = bp_eff;
                     ovf_in  = ovf_eff;
                     res_in.found = found_ff;
                     res_in.done  = 1'b0;
                     if (len_eff >= LEN_W'(PATTERN_MAX)) begin
                        // Pattern full: drop the unit
                        ovf_in     = 1'b1;
                        res_in.ovf = 1'b1;
                        state_in   = ST_EMIT;
                     end else if (len_eff == '0) begin
                        // First unit: failure value is zero
                        st_we      = 1'b1;
                        st_waddr   = '0;
                        st_wdata   = cmd.code;
                        fl_we      = 1'b1;
                        fl_waddr   = '0;
                        fl_wdata   = '0;
                        bp_in      = '0;
                        len_in     = LEN_W'(1);
                        res_in.ovf = ovf_eff;
                        state_in   = ST_EMIT;
                     end else begin
                        k_in     = (bp_eff >= len_eff) ? '0 : bp_eff;
                        state_in = ST_CMP;
                     end
                  end
                  OP_TITLE_NEW, OP_TITLE_CONT: begin
                     is_new    = (cmd.op == OP_TITLE_NEW);
                     found_eff = is_new ? 1'b0 : found_ff;
                     prog_eff  = is_new ? '0 : prog_ff;
                     found_in  = found_eff;
                     prog_in   = prog_eff;
                     if (len_ff == '0) begin
                        // Empty pattern never matches
                        res_in.found = found_eff;
                        res_in.done  = cmd.last;
                        res_in.ovf   = ovf_ff;
                        if (cmd.last) begin
                           found_in = 1'b0;
                           prog_in  = '0;
                        end
                        state_in = ST_EMIT;
                     end else begin
                        k_in     = (prog_eff >= len_ff) ? '0 : prog_eff;
                        state_in = ST_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CMP: begin
            if ((k_ff != '0) && !hit) begin
               // Fall back through the failure table
               k_in = fl_rdata;
            end else if ((cur_ff.op == OP_PATTERN_NEW) || (cur_ff.op == OP_PATTERN_ADD)) begin
               // Append unit and its failure value
               st_we        = 1'b1;
               fl_we        = 1'b1;
               fl_wdata     = k_next;
               bp_in        = k_next;
               len_in       = len_ff + 1'b1;
               res_in.found = found_ff;
               res_in.done  = 1'b0;
               res_in.ovf   = ovf_ff;
               state_in     = ST_EMIT;
            end else if (k_next >= len_ff) begin
               // Full match: fetch failure value of the last unit
               k_in     = k_next;
               found_in = 1'b1;
               state_in = ST_FIX;
            end else begin
               prog_in      = k_next;
               res_in.found = found_ff;
               res_in.done  = cur_ff.last;
               res_in.ovf   = ovf_ff;
               if (cur_ff.last) begin
                  found_in = 1'b0;
                  prog_in  = '0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_FIX: begin
            res_in.found = 1'b1;
            res_in.done  = cur_ff.last;
            res_in.ovf   = ovf_ff;
            found_in     = !cur_ff.last;
            prog_in      = cur_ff.last ? '0 : fl_rdata;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // Hand the result to the output register when free
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read addresses follow the next fallback index
   assign k_dec    = k_in - LEN_W'(1);
   assign st_raddr = k_in[IDX_W-1:0];
   assign fl_raddr = k_dec[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         bp_ff        <= '0;
         prog_ff      <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         bp_ff        <= bp_in;
         prog_ff      <= prog_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      cur_ff <= cur_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp         = out_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.len  = len_ff;
   assign status.prog = prog_ff;
   assign status.bp   = bp_ff;

endmodule

`default_nettype wire
